>>> rtl/adrc_pkg.sv
// adrc_pkg: shared types, constants and table builder for the compressor
// used by adrc_ctrl, adrc_dp and audio_dynamic_range_compressor
`default_nettype none
package adrc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RMS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd6;

  localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
  localparam logic [12:0] KNEE_RST = 13'd1536;
  localparam logic [15:0] SLOPE_RST = 16'd49152;
  localparam logic [23:0] ATTACK_RST = 24'd16742299;
  localparam logic [23:0] RELEASE_RST = 24'd16773721;
  localparam logic [23:0] RMS_RST = 24'd16770227;

  localparam logic [16:0] LEVEL_FLOOR = 17'd36864;
  localparam logic [31:0] PEAK_SCALE = 32'd394566;
  localparam logic [31:0] POWER_SCALE = 32'd197283;
  localparam logic [31:0] EXP_SCALE = 32'd2786635;
  localparam logic signed [31:0] REDUCE_MARK = -32'sd1677722;
  localparam logic signed [31:0] GAIN_FLOOR = -32'sd1073741824;
  localparam logic [46:0] MS_MAX = 47'h4000_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_MS1, OP_MS2, OP_MS3, OP_MS4, OP_MS5, OP_MS6,
    OP_LOGI, OP_NORM, OP_MINIT, OP_SQR, OP_SQS, OP_NL, OP_DB, OP_LVL, OP_OVER,
    OP_KNEE, OP_KSQ, OP_KDIV0, OP_KDIV, OP_R, OP_GD, OP_GU, OP_EXP, OP_AF,
    OP_LM, OP_LR, OP_LSH, OP_Y, OP_OUT
  } op_t;

  typedef enum logic [1:0] {KNEE_NONE, KNEE_LIN, KNEE_SOFT} knee_t;

  typedef struct packed {
    logic  rms;
    logic  zero;
    logic  norm;
    logic  cnt15;
    logic  cnt20;
    logic  cnt25;
    logic  out_free;
    knee_t knee;
  } stat_t;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q1.30, k = 0..20
  function automatic logic [20:0][30:0] build_pow();
    logic [20:0][30:0] t;
    logic [63:0] cur;
    cur = 64'h2000_0000;
    t[0] = cur[30:0];
    for (int k = 1; k <= 20; k++) begin
      cur = floor_sqrt(cur << 30);
      t[k] = cur[30:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/adrc_ctrl.sv
// adrc_ctrl: sequencer for the compressor datapath
// depends on adrc_pkg (op_t, stat_t, knee_t)
`default_nettype none
module adrc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire adrc_pkg::stat_t stat,
  output adrc_pkg::op_t      op
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_MS1, S_MS2, S_MS3, S_MS4, S_MS5, S_MS6, S_LOGI, S_NORM,
    S_MINIT, S_SQR, S_SQS, S_NL, S_DB, S_LVL, S_OVER, S_KNEE, S_KSQ, S_KDIV0,
    S_KDIV, S_R, S_GD, S_GU, S_EXP, S_AF, S_LM, S_LR, S_LSH, S_Y, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= stat.rms ? S_SQ : S_LOGI;
        S_SQ: state <= S_MS1;
        S_MS1: state <= S_MS2;
        S_MS2: state <= S_MS3;
        S_MS3: state <= S_MS4;
        S_MS4: state <= S_MS5;
        S_MS5: state <= S_MS6;
        S_MS6: state <= S_LOGI;
        S_LOGI: state <= S_NORM;
        S_NORM: begin
          if (stat.zero) state <= S_LVL;
          else if (stat.norm) state <= S_MINIT;
        end
        S_MINIT: state <= S_SQR;
        S_SQR: state <= S_SQS;
        S_SQS: state <= stat.cnt15 ? S_NL : S_SQR;
        S_NL: state <= S_DB;
        S_DB: state <= S_LVL;
        S_LVL: state <= S_OVER;
        S_OVER: state <= S_KNEE;
        S_KNEE: state <= (stat.knee == adrc_pkg::KNEE_SOFT) ? S_KSQ : S_R;
        S_KSQ: state <= S_KDIV0;
        S_KDIV0: state <= S_KDIV;
        S_KDIV: if (stat.cnt25) state <= S_R;
        S_R: state <= S_GD;
        S_GD: state <= S_GU;
        S_GU: state <= S_EXP;
        S_EXP: state <= S_AF;
        S_AF: state <= S_LM;
        S_LM: state <= S_LR;
        S_LR: state <= stat.cnt20 ? S_LSH : S_LM;
        S_LSH: state <= S_Y;
        S_Y: state <= S_OUT;
        S_OUT: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE: op = in_valid ? adrc_pkg::OP_LOAD : adrc_pkg::OP_NONE;
      S_SQ: op = adrc_pkg::OP_SQ;
      S_MS1: op = adrc_pkg::OP_MS1;
      S_MS2: op = adrc_pkg::OP_MS2;
      S_MS3: op = adrc_pkg::OP_MS3;
      S_MS4: op = adrc_pkg::OP_MS4;
      S_MS5: op = adrc_pkg::OP_MS5;
      S_MS6: op = adrc_pkg::OP_MS6;
      S_LOGI: op = adrc_pkg::OP_LOGI;
      S_NORM: op = (stat.zero || stat.norm) ? adrc_pkg::OP_NONE : adrc_pkg::OP_NORM;
      S_MINIT: op = adrc_pkg::OP_MINIT;
      S_SQR: op = adrc_pkg::OP_SQR;
      S_SQS: op = adrc_pkg::OP_SQS;
      S_NL: op = adrc_pkg::OP_NL;
      S_DB: op = adrc_pkg::OP_DB;
      S_LVL: op = adrc_pkg::OP_LVL;
      S_OVER: op = adrc_pkg::OP_OVER;
      S_KNEE: op = adrc_pkg::OP_KNEE;
      S_KSQ: op = adrc_pkg::OP_KSQ;
      S_KDIV0: op = adrc_pkg::OP_KDIV0;
      S_KDIV: op = adrc_pkg::OP_KDIV;
      S_R: op = adrc_pkg::OP_R;
      S_GD: op = adrc_pkg::OP_GD;
      S_GU: op = adrc_pkg::OP_GU;
      S_EXP: op = adrc_pkg::OP_EXP;
      S_AF: op = adrc_pkg::OP_AF;
      S_LM: op = adrc_pkg::OP_LM;
      S_LR: op = adrc_pkg::OP_LR;
      S_LSH: op = adrc_pkg::OP_LSH;
      S_Y: op = adrc_pkg::OP_Y;
      // keep the output product alive while the result waits
      S_OUT: op = stat.out_free ? adrc_pkg::OP_OUT : adrc_pkg::OP_Y;
      default: op = adrc_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/adrc_dp.sv
// adrc_dp: compressor datapath with config registers, shared multiplier,
// log2 normalizer, knee divider, gain smoother and output register; uses adrc_pkg
`default_nettype none
module adrc_dp #(
  parameter int SAMPLE_WIDTH = adrc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire adrc_pkg::op_t                       op,
  output adrc_pkg::stat_t                          stat,
  input  wire logic                                cfg_valid,
  input  wire logic [adrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [adrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
  output logic signed [14:0]                       gain_db,
  output logic                                     reducing,
  output logic                                     out_valid,
  input  wire logic                                out_ready
);

  localparam int W = SAMPLE_WIDTH;
  localparam int SQ_R = (2 * W >= 48) ? 2 * W - 48 : 0;
  localparam int SQ_L = (2 * W >= 48) ? 0 : 48 - 2 * W;
  localparam logic [21:0] PEAK_BASE = 22'((W - 1) * 65536);
  localparam logic [21:0] RMS_BASE = 22'(46 * 65536);
  localparam logic [20:0][30:0] POW = adrc_pkg::build_pow();

  logic signed [14:0] threshold_db;
  logic [12:0] knee_width_db;
  logic [15:0] ratio_slope;
  logic [23:0] attack_coeff;
  logic [23:0] release_coeff;
  logic [23:0] rms_coeff;
  logic detect_mode;

  logic neg;
  logic [W-1:0] mag;
  logic [63:0] prod;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [46:0] sqv;
  logic [46:0] ms;
  logic [47:0] acc_hi;
  logic [49:0] acc_lo;
  logic [47:0] nv;
  logic [5:0] p;
  logic zflag;
  logic [31:0] m;
  logic [15:0] frac;
  logic [4:0] cnt;
  logic [21:0] nl;
  logic signed [16:0] level;
  logic signed [17:0] over;
  adrc_pkg::knee_t kc;
  logic [25:0] divn;
  logic [12:0] rem;
  logic [14:0] r;
  logic signed [31:0] g;
  logic dneg;
  logic [4:0] n_sh;
  logic [19:0] f;
  logic [30:0] lin;

  // combinational helpers
  logic signed [18:0] twice;
  logic signed [18:0] kw_s;
  logic [13:0] x2;
  adrc_pkg::knee_t knee_now;
  logic [24:0] dcoef;
  logic [24:0] dms;
  logic signed [31:0] target;
  logic signed [32:0] diff;
  logic [30:0] absdiff;
  logic [30:0] e;
  logic [33:0] sq_t;
  logic [13:0] rem2;
  logic [16:0] dbn;
  logic [22:0] nl_s;
  logic [31:0] step;
  logic signed [33:0] gn;
  logic [34:0] rlin;
  logic [63:0] qv;
  logic [25:0] divq0;
  logic [24:0] a_v;
  logic [30:0] lin_r;
  logic [47:0] ms_new;

  assign twice = 19'(over) <<< 1;
  assign kw_s = $signed({6'b0, knee_width_db});
  assign x2 = 14'(twice + kw_s);
  assign target = -$signed({1'b0, r, 16'b0});
  assign diff = 33'(target) - 33'(g);
  assign absdiff = diff[32] ? 31'(-diff) : 31'(diff);
  assign dcoef = 25'h100_0000 - {1'b0, (target < g) ? attack_coeff : release_coeff};
  assign dms = 25'h100_0000 - {1'b0, rms_coeff};
  assign e = 31'(-g);
  assign sq_t = prod[63:30];
  assign rem2 = {rem, divn[25]};
  assign nl_s = {1'b0, detect_mode ? RMS_BASE : PEAK_BASE} - {1'b0, p, 16'b0}
                - {7'b0, frac};
  assign dbn = 17'((prod[40:0] + 41'h80_0000) >> 24);
  assign step = 32'((prod[55:0] + 56'h80_0000) >> 24);
  assign gn = dneg ? 34'(g) - $signed({2'b0, step}) : 34'(g) + $signed({2'b0, step});
  assign rlin = 35'((prod[32:0] + 33'h8000) >> 16);
  assign qv = (prod + 64'h2000_0000) >> 30;
  assign divq0 = 26'((prod[44:0] + {14'b0, knee_width_db, 18'b0}) >> 19);
  assign a_v = 25'((prod[52:0] + 53'h800_0000) >> 28);
  assign lin_r = 31'((prod[61:0] + 62'h2000_0000) >> 30);
  assign ms_new = acc_hi + 48'((acc_lo + 50'h80_0000) >> 24);

  always_comb begin
    knee_now = adrc_pkg::KNEE_NONE;
    if (knee_width_db != '0) begin
      if (twice >= kw_s) knee_now = adrc_pkg::KNEE_LIN;
      else if (twice > -kw_s) knee_now = adrc_pkg::KNEE_SOFT;
    end else if (over > 0) begin
      knee_now = adrc_pkg::KNEE_LIN;
    end
  end

  always_comb begin
    unique case (op)
      adrc_pkg::OP_SQ: begin ma = 32'(mag); mb = 32'(mag); end
      adrc_pkg::OP_MS1: begin ma = {8'b0, rms_coeff}; mb = {9'b0, ms[46:24]}; end
      adrc_pkg::OP_MS2: begin ma = {7'b0, dms}; mb = {9'b0, sqv[46:24]}; end
      adrc_pkg::OP_MS3: begin ma = {8'b0, rms_coeff}; mb = {8'b0, ms[23:0]}; end
      adrc_pkg::OP_MS4: begin ma = {7'b0, dms}; mb = {8'b0, sqv[23:0]}; end
      adrc_pkg::OP_SQR: begin ma = m; mb = m; end
      adrc_pkg::OP_DB: begin
        ma = {10'b0, nl};
        mb = detect_mode ? adrc_pkg::POWER_SCALE : adrc_pkg::PEAK_SCALE;
      end
      adrc_pkg::OP_KNEE: begin
        if (knee_now == adrc_pkg::KNEE_SOFT) begin
          ma = {18'b0, x2}; mb = {18'b0, x2};
        end else begin
          ma = {15'b0, over[16:0]}; mb = {16'b0, ratio_slope};
        end
      end
      adrc_pkg::OP_KSQ: begin ma = {4'b0, prod[27:0]}; mb = {16'b0, ratio_slope}; end
      adrc_pkg::OP_GD: begin ma = {1'b0, absdiff}; mb = {7'b0, dcoef}; end
      adrc_pkg::OP_EXP: begin ma = {1'b0, e}; mb = adrc_pkg::EXP_SCALE; end
      adrc_pkg::OP_LM: begin ma = {1'b0, lin}; mb = {1'b0, POW[cnt]}; end
      adrc_pkg::OP_Y: begin ma = 32'(mag); mb = {1'b0, lin}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    stat.rms = detect_mode;
    stat.zero = zflag;
    stat.norm = nv[47];
    stat.cnt15 = (cnt == 5'd15);
    stat.cnt20 = (cnt == 5'd20);
    stat.cnt25 = (cnt == 5'd25);
    stat.out_free = !out_valid || out_ready;
    stat.knee = knee_now;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db <= adrc_pkg::THRESHOLD_RST;
      knee_width_db <= adrc_pkg::KNEE_RST;
      ratio_slope <= adrc_pkg::SLOPE_RST;
      attack_coeff <= adrc_pkg::ATTACK_RST;
      release_coeff <= adrc_pkg::RELEASE_RST;
      rms_coeff <= adrc_pkg::RMS_RST;
      detect_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        adrc_pkg::REG_THRESHOLD: threshold_db <= $signed(cfg_data[14:0]);
        adrc_pkg::REG_KNEE: knee_width_db <= cfg_data[12:0];
        adrc_pkg::REG_SLOPE: ratio_slope <= cfg_data[15:0];
        adrc_pkg::REG_ATTACK: attack_coeff <= cfg_data;
        adrc_pkg::REG_RELEASE: release_coeff <= cfg_data;
        adrc_pkg::REG_RMS: rms_coeff <= cfg_data;
        adrc_pkg::REG_MODE: detect_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // filter state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ms <= '0;
      g <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == adrc_pkg::OP_MS6) ms <= (ms_new > 48'(adrc_pkg::MS_MAX)) ?
                                         adrc_pkg::MS_MAX : ms_new[46:0];
      if (op == adrc_pkg::OP_GU) begin
        if (gn > 0) g <= '0;
        else if (gn < 34'(adrc_pkg::GAIN_FLOOR)) g <= adrc_pkg::GAIN_FLOOR;
        else g <= gn[31:0];
      end
      if (op == adrc_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
    case (op)
      adrc_pkg::OP_LOAD: begin
        neg <= sample_in[W-1];
        mag <= sample_in[W-1] ? W'(-sample_in) : W'(sample_in);
      end
      adrc_pkg::OP_MS1: sqv <= 47'((prod >> SQ_R) << SQ_L);
      adrc_pkg::OP_MS2: acc_hi <= prod[47:0];
      adrc_pkg::OP_MS3: acc_hi <= acc_hi + prod[47:0];
      adrc_pkg::OP_MS4: acc_lo <= prod[49:0];
      adrc_pkg::OP_MS5: acc_lo <= acc_lo + prod[49:0];
      adrc_pkg::OP_LOGI: begin
        nv <= detect_mode ? {1'b0, ms} : 48'(mag);
        zflag <= detect_mode ? (ms == '0) : (mag == '0);
        p <= 6'd47;
      end
      adrc_pkg::OP_NORM: begin
        if (nv[47:40] == '0) begin
          nv <= nv << 8;
          p <= p - 6'd8;
        end else begin
          nv <= nv << 1;
          p <= p - 6'd1;
        end
      end
      adrc_pkg::OP_MINIT: begin
        m <= {1'b0, nv[47:17]};
        frac <= '0;
        cnt <= '0;
      end
      adrc_pkg::OP_SQS: begin
        frac <= {frac[14:0], sq_t[31]};
        m <= sq_t[31] ? sq_t[32:1] : sq_t[31:0];
        cnt <= cnt + 5'd1;
      end
      adrc_pkg::OP_NL: nl <= nl_s[22] ? '0 : nl_s[21:0];
      adrc_pkg::OP_LVL: begin
        if (zflag || dbn > adrc_pkg::LEVEL_FLOOR) level <= -$signed(adrc_pkg::LEVEL_FLOOR);
        else level <= -$signed(dbn);
      end
      adrc_pkg::OP_OVER: over <= 18'(level) - 18'(threshold_db);
      adrc_pkg::OP_KNEE: kc <= knee_now;
      adrc_pkg::OP_KDIV0: begin
        divn <= divq0;
        rem <= '0;
        cnt <= '0;
      end
      adrc_pkg::OP_KDIV: begin
        if (rem2 >= {1'b0, knee_width_db}) begin
          rem <= 13'(rem2 - {1'b0, knee_width_db});
          divn <= {divn[24:0], 1'b1};
        end else begin
          rem <= rem2[12:0];
          divn <= {divn[24:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      adrc_pkg::OP_R: begin
        if (kc == adrc_pkg::KNEE_LIN) r <= (rlin > 35'd16384) ? 15'd16384 : rlin[14:0];
        else if (kc == adrc_pkg::KNEE_SOFT) r <= (divn > 26'd16384) ? 15'd16384 : divn[14:0];
        else r <= '0;
      end
      adrc_pkg::OP_GD: dneg <= diff[32];
      adrc_pkg::OP_AF: begin
        n_sh <= a_v[24:20];
        f <= a_v[19:0];
        lin <= 31'h4000_0000;
        cnt <= 5'd1;
      end
      adrc_pkg::OP_LR: begin
        if (f[5'(5'd20 - cnt)]) lin <= lin_r;
        cnt <= cnt + 5'd1;
      end
      adrc_pkg::OP_LSH: lin <= lin >> n_sh;
      adrc_pkg::OP_OUT: begin
        sample_out <= neg ? W'(-qv) : W'(qv);
        gain_db <= 15'(-(({1'b0, e} + 32'h8000) >> 16));
        reducing <= (g <= adrc_pkg::REDUCE_MARK);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/audio_dynamic_range_compressor.sv
// audio_dynamic_range_compressor: top level, joins sequencer and datapath
// depends on adrc_pkg, adrc_ctrl, adrc_dp
//
// usage:
//   input channel in_valid/in_ready/sample_in takes one signed sample per
//   transaction; output channel out_valid/out_ready carries sample_out,
//   gain_db and reducing for that sample.
//   config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes register
//   cfg_index (0 threshold, 1 knee, 2 slope, 3 attack, 4 release, 5 rms,
//   6 mode); cfg_ready is always high, write only while the block is idle.
//   a zero sample (or a zero mean square in rms mode) skips the log2 step,
//   and a level inside the soft knee adds the knee divider. the log2 step
//   (normalize, then 16 squarings), the 26 step knee divider and the 20
//   step exponent loop all share one 32x32 multiplier. one sample is in
//   flight at a time; in_ready rises in the same cycle as the result
//   appears in the output register, and the next sample is taken while
//   that result waits.
//   if the receiver stalls, the block finishes the next sample and holds
//   it until the output register frees.
//   reset loads the register defaults, 0 dB gain and zero mean square.
`default_nettype none
module audio_dynamic_range_compressor #(
  parameter int SAMPLE_WIDTH = adrc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]          sample_out,
  output logic signed [14:0]                      gain_db,
  output logic                                    reducing,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [adrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [adrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  adrc_pkg::op_t op;
  adrc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  adrc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat(stat),
    .op(op)
  );

  adrc_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk),
    .rst(rst),
    .op(op),
    .stat(stat),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_in(sample_in),
    .sample_out(sample_out),
    .gain_db(gain_db),
    .reducing(reducing),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule
`default_nettype wire
